>>> src/bfq_pkg.sv
package bfq_pkg;

    localparam int DATA_W    = 16;
    localparam int CNT_W     = 6;
    localparam int BYTES_W   = 25;
    localparam int LIMIT_W   = 24;
    localparam int TOTAL_W   = 32;
    localparam int KIND_W    = 3;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [CMD_W-1:0] CMD_ENQ   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STATS = 2'd2;

    localparam logic [KIND_W-1:0] KIND_QUEUED    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CONG      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ARR_DROP  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_HEAD_DROP = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DEQ       = 3'd4;
    localparam logic [KIND_W-1:0] KIND_EMPTY     = 3'd5;
    localparam logic [KIND_W-1:0] KIND_STATS     = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_MODE  = 1'd1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'd1500000;
    localparam logic               MODE_HEAD   = 1'b0;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [DATA_W-1:0] packet_tag;
        logic [DATA_W-1:0] packet_length;
    } t_in;

    typedef struct packed {
        logic [KIND_W-1:0]  result_kind;
        logic [DATA_W-1:0]  out_tag;
        logic [DATA_W-1:0]  out_length;
        logic               is_last;
        logic [TOTAL_W-1:0] packet_total;
        logic [TOTAL_W-1:0] drop_total;
        logic [CNT_W-1:0]   depth_peak;
        logic [BYTES_W-1:0] peak_backlog;
        logic [CNT_W-1:0]   queued_packets;
        logic [BYTES_W-1:0] queued_bytes;
    } t_out;

    typedef struct packed {
        logic [BYTES_W-1:0] diff;
        logic [BYTES_W-1:0] sum;
        logic               over;
    } t_fit;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_POP,
        S_EREAD,
        S_EMIT,
        S_FINAL
    } t_state;

endpackage

>>> src/bfq_fit.sv
module bfq_fit (
    input  logic [bfq_pkg::BYTES_W-1:0] i_backlog,
    input  logic [bfq_pkg::DATA_W-1:0]  i_sub_len,
    input  logic [bfq_pkg::DATA_W-1:0]  i_add_len,
    input  logic [bfq_pkg::LIMIT_W-1:0] i_limit,
    input  logic                        i_full,
    output bfq_pkg::t_fit               o_fit
);

    logic [bfq_pkg::BYTES_W-1:0] diff;
    logic [bfq_pkg::BYTES_W-1:0] sum;

    assign diff = i_backlog - bfq_pkg::BYTES_W'(i_sub_len);
    assign sum  = diff + bfq_pkg::BYTES_W'(i_add_len);

    assign o_fit.diff = diff;
    assign o_fit.sum  = sum;
    assign o_fit.over = i_full || (sum > bfq_pkg::BYTES_W'(i_limit));

endmodule

>>> src/byte_fifo_head_drop_queue_core.sv
// Steps: an enqueue that fits, a tail drop, a dequeue on empty and a stats read go from
// execute to the final beat; a dequeue reads, pops, then gives its final beat. Head drop:
// a read and a pop per dropped packet to scan the descriptor store, a read and an emit per
// head-drop beat, then the final beat. One item at a time, ready again once its last beat is loaded.
// Reset (synchronous, active low) clears queue state, counters, peaks, output valid, limit and
// drop mode; the descriptor store, output data and staging registers are not cleared.
module byte_fifo_head_drop_queue_core #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  bfq_pkg::t_in                  i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output bfq_pkg::t_out                 o_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bfq_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bfq_pkg::LIMIT_W-1:0]   i_cfg_data
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int MW = 2 * bfq_pkg::DATA_W;
    localparam logic [CW-1:0] DEPTH_C   = CW'(QUEUE_DEPTH);
    localparam logic [AW:0]   DEPTH_W   = (AW+1)'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_IDX  = AW'(QUEUE_DEPTH - 1);

    bfq_pkg::t_state r_state, n_state;

    logic [AW-1:0]                r_head, n_head;
    logic [CW-1:0]                r_count, n_count;
    logic [bfq_pkg::BYTES_W-1:0]  r_backlog, n_backlog;
    logic [bfq_pkg::TOTAL_W-1:0]  r_pkts, n_pkts;
    logic [bfq_pkg::TOTAL_W-1:0]  r_drops, n_drops;
    logic [bfq_pkg::CNT_W-1:0]    r_cpeak, n_cpeak;
    logic [bfq_pkg::BYTES_W-1:0]  r_bpeak, n_bpeak;
    logic [bfq_pkg::LIMIT_W-1:0]  r_limit;
    logic                         r_mode;
    logic                         r_out_valid, n_out_valid;

    logic [bfq_pkg::CMD_W-1:0]    r_cmd, n_cmd;
    logic [bfq_pkg::DATA_W-1:0]   r_tag, n_tag;
    logic [bfq_pkg::DATA_W-1:0]   r_len, n_len;
    logic [bfq_pkg::KIND_W-1:0]   r_kind, n_kind;
    logic [bfq_pkg::DATA_W-1:0]   r_res_tag, n_res_tag;
    logic [bfq_pkg::DATA_W-1:0]   r_res_len, n_res_len;
    logic                         r_push, n_push;
    logic                         r_clear, n_clear;
    logic [AW-1:0]                r_emit_idx, n_emit_idx;
    logic [CW-1:0]                r_emit_cnt, n_emit_cnt;
    bfq_pkg::t_out                r_out, n_out;

    logic [MW-1:0]                r_store [QUEUE_DEPTH];
    logic [MW-1:0]                r_rd_data;

    logic [AW-1:0]                rd_addr;
    logic [AW:0]                  tail_sum;
    logic [AW-1:0]                tail;
    logic                         mem_we;
    logic                         out_free;
    logic [bfq_pkg::DATA_W-1:0]   rd_tag;
    logic [bfq_pkg::DATA_W-1:0]   rd_len;
    logic [bfq_pkg::DATA_W-1:0]   fit_sub;
    logic [bfq_pkg::DATA_W-1:0]   fit_add;
    logic                         fit_full;
    bfq_pkg::t_fit                fit;

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] a);
        f_next = (a == LAST_IDX) ? '0 : a + 1'b1;
    endfunction

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == bfq_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign rd_tag   = r_rd_data[MW-1:bfq_pkg::DATA_W];
    assign rd_len   = r_rd_data[bfq_pkg::DATA_W-1:0];
    assign tail_sum = {1'b0, r_head} + (AW+1)'(r_count);
    assign tail     = (tail_sum >= DEPTH_W) ? AW'(tail_sum - DEPTH_W) : AW'(tail_sum);
    assign rd_addr  = (r_state == bfq_pkg::S_EREAD || r_state == bfq_pkg::S_EMIT) ?
                      r_emit_idx : r_head;
    assign mem_we   = (r_state == bfq_pkg::S_FINAL) && out_free && r_push;

    assign fit_sub  = (r_state == bfq_pkg::S_POP) ? rd_len : '0;
    assign fit_add  = (r_cmd == bfq_pkg::CMD_ENQ) ? r_len : '0;
    assign fit_full = (r_state == bfq_pkg::S_EXEC) && (r_count == DEPTH_C);

    bfq_fit u_fit (
        .i_backlog (r_backlog),
        .i_sub_len (fit_sub),
        .i_add_len (fit_add),
        .i_limit   (r_limit),
        .i_full    (fit_full),
        .o_fit     (fit)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            bfq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = bfq_pkg::S_EXEC;
                end
            end
            bfq_pkg::S_EXEC: begin
                case (r_cmd)
                    bfq_pkg::CMD_ENQ: begin
                        if (fit.over && r_mode == bfq_pkg::MODE_HEAD && r_count != '0) begin
                            n_state = bfq_pkg::S_READ;
                        end else begin
                            n_state = bfq_pkg::S_FINAL;
                        end
                    end
                    bfq_pkg::CMD_DEQ: begin
                        n_state = (r_count != '0) ? bfq_pkg::S_READ : bfq_pkg::S_FINAL;
                    end
                    bfq_pkg::CMD_STATS: begin
                        n_state = bfq_pkg::S_FINAL;
                    end
                    default: begin
                        n_state = bfq_pkg::S_IDLE;
                    end
                endcase
            end
            bfq_pkg::S_READ: begin
                n_state = bfq_pkg::S_POP;
            end
            bfq_pkg::S_POP: begin
                if (r_cmd == bfq_pkg::CMD_DEQ) begin
                    n_state = bfq_pkg::S_FINAL;
                end else if (r_count != CW'(1) && fit.over) begin
                    n_state = bfq_pkg::S_READ;
                end else begin
                    n_state = bfq_pkg::S_EREAD;
                end
            end
            bfq_pkg::S_EREAD: begin
                n_state = bfq_pkg::S_EMIT;
            end
            bfq_pkg::S_EMIT: begin
                if (out_free) begin
                    n_state = (r_emit_cnt == CW'(1)) ? bfq_pkg::S_FINAL : bfq_pkg::S_EREAD;
                end
            end
            bfq_pkg::S_FINAL: begin
                if (out_free) begin
                    n_state = bfq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bfq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_backlog   = r_backlog;
        n_pkts      = r_pkts;
        n_drops     = r_drops;
        n_cpeak     = r_cpeak;
        n_bpeak     = r_bpeak;
        n_cmd       = r_cmd;
        n_tag       = r_tag;
        n_len       = r_len;
        n_kind      = r_kind;
        n_res_tag   = r_res_tag;
        n_res_len   = r_res_len;
        n_push      = r_push;
        n_clear     = r_clear;
        n_emit_idx  = r_emit_idx;
        n_emit_cnt  = r_emit_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        n_out.packet_total   = r_pkts;
        n_out.drop_total     = r_drops;
        n_out.depth_peak     = r_cpeak;
        n_out.peak_backlog   = r_bpeak;
        n_out.queued_packets = bfq_pkg::CNT_W'(r_count) + bfq_pkg::CNT_W'(r_push);
        n_out.queued_bytes   = r_push ? fit.sum : r_backlog;

        case (r_state)
            bfq_pkg::S_IDLE: begin
                n_out = r_out;
                if (i_in_valid) begin
                    n_cmd   = i_in.command;
                    n_tag   = i_in.packet_tag;
                    n_len   = i_in.packet_length;
                    n_push  = 1'b0;
                    n_clear = 1'b0;
                end
            end
            bfq_pkg::S_EXEC: begin
                n_out      = r_out;
                n_res_tag  = '0;
                n_res_len  = '0;
                n_emit_idx = r_head;
                n_emit_cnt = '0;
                case (r_cmd)
                    bfq_pkg::CMD_ENQ: begin
                        n_pkts    = r_pkts + 1'b1;
                        n_res_tag = r_tag;
                        n_res_len = r_len;
                        if (bfq_pkg::CNT_W'(r_count) >= r_cpeak) begin
                            n_cpeak = (r_count == DEPTH_C) ? bfq_pkg::CNT_W'(DEPTH_C) :
                                      bfq_pkg::CNT_W'(r_count + 1'b1);
                        end
                        if (fit.sum > r_bpeak) begin
                            n_bpeak = fit.sum;
                        end
                        if (!fit.over) begin
                            n_kind = bfq_pkg::KIND_QUEUED;
                            n_push = 1'b1;
                        end else if (r_mode != bfq_pkg::MODE_HEAD) begin
                            n_kind  = bfq_pkg::KIND_ARR_DROP;
                            n_drops = r_drops + 1'b1;
                        end else begin
                            n_kind = bfq_pkg::KIND_CONG;
                            n_push = 1'b1;
                        end
                    end
                    bfq_pkg::CMD_DEQ: begin
                        n_kind = bfq_pkg::KIND_EMPTY;
                    end
                    bfq_pkg::CMD_STATS: begin
                        n_kind  = bfq_pkg::KIND_STATS;
                        n_clear = 1'b1;
                    end
                    default: begin
                        n_kind = r_kind;
                    end
                endcase
            end
            bfq_pkg::S_POP: begin
                n_out     = r_out;
                n_head    = f_next(r_head);
                n_count   = r_count - 1'b1;
                n_backlog = fit.diff;
                if (r_cmd == bfq_pkg::CMD_DEQ) begin
                    n_kind    = bfq_pkg::KIND_DEQ;
                    n_res_tag = rd_tag;
                    n_res_len = rd_len;
                end else begin
                    n_drops    = r_drops + 1'b1;
                    n_emit_cnt = r_emit_cnt + 1'b1;
                end
            end
            bfq_pkg::S_EMIT: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.result_kind = bfq_pkg::KIND_HEAD_DROP;
                    n_out.out_tag     = rd_tag;
                    n_out.out_length  = rd_len;
                    n_out.is_last     = 1'b0;
                    n_emit_idx        = f_next(r_emit_idx);
                    n_emit_cnt        = r_emit_cnt - 1'b1;
                end else begin
                    n_out = r_out;
                end
            end
            bfq_pkg::S_FINAL: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.result_kind = r_kind;
                    n_out.out_tag     = r_res_tag;
                    n_out.out_length  = r_res_len;
                    n_out.is_last     = 1'b1;
                    if (r_push) begin
                        n_count   = r_count + 1'b1;
                        n_backlog = fit.sum;
                    end
                    if (r_clear) begin
                        n_cpeak = '0;
                        n_bpeak = '0;
                    end
                end else begin
                    n_out = r_out;
                end
            end
            default: begin
                n_out = r_out;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bfq_pkg::S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_backlog   <= '0;
            r_pkts      <= '0;
            r_drops     <= '0;
            r_cpeak     <= '0;
            r_bpeak     <= '0;
            r_out_valid <= 1'b0;
            r_push      <= 1'b0;
            r_clear     <= 1'b0;
            r_limit     <= bfq_pkg::LIMIT_RESET;
            r_mode      <= bfq_pkg::MODE_HEAD;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_backlog   <= n_backlog;
            r_pkts      <= n_pkts;
            r_drops     <= n_drops;
            r_cpeak     <= n_cpeak;
            r_bpeak     <= n_bpeak;
            r_out_valid <= n_out_valid;
            r_push      <= n_push;
            r_clear     <= n_clear;
            if (i_cfg_valid && i_cfg_index == bfq_pkg::CFG_BYTE_LIMIT) begin
                r_limit <= i_cfg_data;
            end
            if (i_cfg_valid && i_cfg_index == bfq_pkg::CFG_DROP_MODE) begin
                r_mode <= i_cfg_data[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_tag      <= n_tag;
        r_len      <= n_len;
        r_kind     <= n_kind;
        r_res_tag  <= n_res_tag;
        r_res_len  <= n_res_len;
        r_emit_idx <= n_emit_idx;
        r_emit_cnt <= n_emit_cnt;
        r_out      <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[tail] <= {r_tag, r_len};
        end
        r_rd_data <= r_store[rd_addr];
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("queue count above depth");

    a_emit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bfq_pkg::S_EMIT) |-> (r_emit_cnt != '0))
        else $error("head-drop beat with no pending drop");

    a_drop_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.result_kind == bfq_pkg::KIND_HEAD_DROP) |-> !o_out.is_last)
        else $error("head-drop beat marked last");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bfq_pkg::S_POP) |=> (r_count == CW'($past(r_count) - 1'b1)))
        else $error("pop did not decrement count");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bfq_pkg::S_READ) |-> (r_count != '0))
        else $error("pop issued on empty queue");

endmodule
